FILE: rtl/core/wtcs_pkg.sv
// ----------------------------------------------------------------------------
// wtcs_pkg
// Types and constants shared by the wall texture column sampler modules.
// ----------------------------------------------------------------------------
package wtcs_pkg;

    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int SIDE_W   = 2;
    localparam int WALL_H_W = 16;
    localparam int FRAC_W   = 16;
    localparam int NOM_W    = 11;
    localparam int TEX_X_W  = 10;
    localparam int TY_OUT_W = 11;
    localparam int PITCH_W  = 15;
    localparam int BPT_W    = 4;
    localparam int SCREEN_W = 13;
    localparam int COLOR_W  = 32;
    localparam int TX_OFF_W = 14;
    localparam int OFFSET_W = 24;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_NOMINAL_TEX_WIDTH  = 3'd0;
    localparam logic [2:0] REG_NOMINAL_TEX_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TEX_WIDTH          = 3'd2;
    localparam logic [2:0] REG_TEX_HEIGHT         = 3'd3;
    localparam logic [2:0] REG_ROW_PITCH          = 3'd4;
    localparam logic [2:0] REG_BYTES_PER_TEXEL    = 3'd5;
    localparam logic [2:0] REG_SCREEN_HEIGHT      = 3'd6;
    localparam logic [2:0] REG_FALLBACK_COLOR     = 3'd7;

    localparam logic [NOM_W-1:0]    RST_NOMINAL_TEX_WIDTH  = 11'd64;
    localparam logic [NOM_W-1:0]    RST_NOMINAL_TEX_HEIGHT = 11'd64;
    localparam logic [NOM_W-1:0]    RST_TEX_WIDTH          = 11'd64;
    localparam logic [NOM_W-1:0]    RST_TEX_HEIGHT         = 11'd64;
    localparam logic [PITCH_W-1:0]  RST_ROW_PITCH          = 15'd256;
    localparam logic [BPT_W-1:0]    RST_BYTES_PER_TEXEL    = 4'd4;
    localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT      = 13'd1080;
    localparam logic [COLOR_W-1:0]  RST_FALLBACK_COLOR     = 32'd0;

    typedef struct packed {
        logic [NOM_W-1:0]    nominal_tex_width;
        logic [NOM_W-1:0]    nominal_tex_height;
        logic [NOM_W-1:0]    tex_width;
        logic [NOM_W-1:0]    tex_height;
        logic [PITCH_W-1:0]  row_pitch;
        logic [BPT_W-1:0]    bytes_per_texel;
        logic [SCREEN_W-1:0] screen_height;
        logic [COLOR_W-1:0]  fallback_color;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [SIDE_W-1:0]   side;
        logic [ROW_W-1:0]    first_row;
        logic [ROW_W-1:0]    end_row;
        logic [TEX_X_W-1:0]  tex_x;
        logic [TX_OFF_W-1:0] tx_off;
    } seg_t;

endpackage

FILE: rtl/core/wtcs_regs.sv
// ----------------------------------------------------------------------------
// wtcs_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module wtcs_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wtcs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wtcs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wtcs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output wtcs_pkg::cfg_t                    cfg
);

    wtcs_pkg::cfg_t cfg_reg;
    logic [2:0]     index;
    logic           wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nominal_tex_width  <= wtcs_pkg::RST_NOMINAL_TEX_WIDTH;
            cfg_reg.nominal_tex_height <= wtcs_pkg::RST_NOMINAL_TEX_HEIGHT;
            cfg_reg.tex_width          <= wtcs_pkg::RST_TEX_WIDTH;
            cfg_reg.tex_height         <= wtcs_pkg::RST_TEX_HEIGHT;
            cfg_reg.row_pitch          <= wtcs_pkg::RST_ROW_PITCH;
            cfg_reg.bytes_per_texel    <= wtcs_pkg::RST_BYTES_PER_TEXEL;
            cfg_reg.screen_height      <= wtcs_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.fallback_color     <= wtcs_pkg::RST_FALLBACK_COLOR;
        end
        else if (wr_en)
        begin
            unique case (index)
                wtcs_pkg::REG_NOMINAL_TEX_WIDTH:
                    cfg_reg.nominal_tex_width <= pwdata[wtcs_pkg::NOM_W-1:0];
                wtcs_pkg::REG_NOMINAL_TEX_HEIGHT:
                    cfg_reg.nominal_tex_height <= pwdata[wtcs_pkg::NOM_W-1:0];
                wtcs_pkg::REG_TEX_WIDTH:
                    cfg_reg.tex_width <= pwdata[wtcs_pkg::NOM_W-1:0];
                wtcs_pkg::REG_TEX_HEIGHT:
                    cfg_reg.tex_height <= pwdata[wtcs_pkg::NOM_W-1:0];
                wtcs_pkg::REG_ROW_PITCH:
                    cfg_reg.row_pitch <= pwdata[wtcs_pkg::PITCH_W-1:0];
                wtcs_pkg::REG_BYTES_PER_TEXEL:
                    cfg_reg.bytes_per_texel <= pwdata[wtcs_pkg::BPT_W-1:0];
                wtcs_pkg::REG_SCREEN_HEIGHT:
                    cfg_reg.screen_height <= pwdata[wtcs_pkg::SCREEN_W-1:0];
                wtcs_pkg::REG_FALLBACK_COLOR:
                    cfg_reg.fallback_color <= pwdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            wtcs_pkg::REG_NOMINAL_TEX_WIDTH:  prdata = 32'(cfg_reg.nominal_tex_width);
            wtcs_pkg::REG_NOMINAL_TEX_HEIGHT: prdata = 32'(cfg_reg.nominal_tex_height);
            wtcs_pkg::REG_TEX_WIDTH:          prdata = 32'(cfg_reg.tex_width);
            wtcs_pkg::REG_TEX_HEIGHT:         prdata = 32'(cfg_reg.tex_height);
            wtcs_pkg::REG_ROW_PITCH:          prdata = 32'(cfg_reg.row_pitch);
            wtcs_pkg::REG_BYTES_PER_TEXEL:    prdata = 32'(cfg_reg.bytes_per_texel);
            wtcs_pkg::REG_SCREEN_HEIGHT:      prdata = 32'(cfg_reg.screen_height);
            wtcs_pkg::REG_FALLBACK_COLOR:     prdata = cfg_reg.fallback_color;
            default:                          prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/wtcs_front.sv
// ----------------------------------------------------------------------------
// wtcs_front
// Accepts segment requests, drops empty runs, and works out the texture
// column, the per-row step (bit-serial divider) and the start position
// (bit-serial multiplier) before handing the segment to the queue.
// ----------------------------------------------------------------------------
module wtcs_front
#(
    parameter int MAX_ROWS      = 64,
    parameter int FRACTION_BITS = 16,
    parameter int STEP_W        = 27,
    parameter int POS_W         = 45
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  wtcs_pkg::cfg_t                    cfg,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wtcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [wtcs_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              push,
    input  logic                              push_ready,
    output wtcs_pkg::seg_t                    seg,
    output logic [STEP_W-1:0]                 step,
    output logic signed [POS_W-1:0]           pos
);

    localparam int NUM_W = wtcs_pkg::NOM_W + FRACTION_BITS;
    localparam int D_W   = 18;
    localparam int MAG_W = D_W - 1;
    localparam int ACC_W = POS_W - 1;
    localparam int CNT_W = $clog2(NUM_W > MAG_W ? NUM_W : MAG_W);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [CNT_W-1:0] cnt_reg;

    logic [wtcs_pkg::COL_W-1:0]    col_reg;
    logic [wtcs_pkg::SIDE_W-1:0]   side_reg;
    logic [wtcs_pkg::ROW_W-1:0]    first_reg;
    logic [wtcs_pkg::ROW_W-1:0]    end_reg;
    logic [wtcs_pkg::FRAC_W-1:0]   frac_reg;
    logic [wtcs_pkg::WALL_H_W-1:0] wh_reg;
    logic [wtcs_pkg::TEX_X_W-1:0]  tx_reg;
    logic [wtcs_pkg::TX_OFF_W-1:0] tx_off_reg;
    logic [wtcs_pkg::WALL_H_W-1:0] rem_reg;
    logic [wtcs_pkg::WALL_H_W-1:0] rem_next;
    logic [NUM_W-1:0]              quo_reg;
    logic [NUM_W-1:0]              quo_next;
    logic signed [D_W-1:0]         d_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [ACC_W-1:0]              mcand_reg;
    logic [MAG_W-1:0]              mplier_reg;

    logic [wtcs_pkg::COL_W-1:0]    in_column;
    logic [wtcs_pkg::ROW_W-1:0]    in_first;
    logic [wtcs_pkg::ROW_W-1:0]    in_last;
    logic [wtcs_pkg::WALL_H_W-1:0] in_wh;
    logic [wtcs_pkg::FRAC_W-1:0]   in_frac;
    logic [wtcs_pkg::ROW_W-1:0]    span;
    logic [wtcs_pkg::ROW_W-1:0]    end_calc;
    logic                          accept;
    logic                          empty_run;

    logic [wtcs_pkg::WALL_H_W:0]   shifted;
    logic [wtcs_pkg::WALL_H_W+1:0] trial;

    logic [26:0]                   tx_prod;
    logic [wtcs_pkg::NOM_W-1:0]    tx_raw;
    logic [wtcs_pkg::NOM_W-1:0]    tx_clamp;
    logic [wtcs_pkg::TEX_X_W-1:0]  tx_sat;

    logic signed [D_W-1:0]         diff;
    logic signed [D_W-1:0]         half;
    logic signed [D_W-1:0]         d_calc;
    logic [D_W-1:0]                d_abs;
    logic [ACC_W:0]                acc_ext;

    assign in_column = s_axis_tdata[11:0];
    assign in_first  = s_axis_tdata[23:12];
    assign in_last   = s_axis_tdata[35:24];
    assign in_wh     = s_axis_tdata[51:36];
    assign in_frac   = s_axis_tdata[67:52];

    assign s_axis_tready = (state_reg == F_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign empty_run     = (in_last < in_first);
    assign span          = in_last - in_first;
    assign end_calc      = (span >= wtcs_pkg::ROW_W'(MAX_ROWS))
                           ? in_first + wtcs_pkg::ROW_W'(MAX_ROWS - 1) : in_last;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, wh_reg};

    always_comb
    begin
        if (!trial[wtcs_pkg::WALL_H_W+1])
        begin
            rem_next = trial[wtcs_pkg::WALL_H_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[wtcs_pkg::WALL_H_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign tx_prod = 27'(frac_reg) * 27'(cfg.nominal_tex_width);
    assign tx_raw  = tx_prod[26:16];

    always_comb
    begin
        if (cfg.nominal_tex_width == '0)
        begin
            tx_clamp = '0;
        end
        else if (tx_raw >= cfg.nominal_tex_width)
        begin
            tx_clamp = cfg.nominal_tex_width - 11'd1;
        end
        else
        begin
            tx_clamp = tx_raw;
        end
        tx_sat = tx_clamp[10] ? '1 : tx_clamp[wtcs_pkg::TEX_X_W-1:0];
    end

    // Wall centring: half of (screen height - wall height), rounded toward zero.
    assign diff   = $signed(D_W'(cfg.screen_height)) - $signed(D_W'(wh_reg));
    assign half   = (diff + $signed(D_W'(diff[D_W-1]))) >>> 1;
    assign d_calc = $signed(D_W'(first_reg)) - half;
    assign d_abs  = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && !empty_run)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg   <= in_column;
            side_reg  <= s_axis_tuser;
            first_reg <= in_first;
            end_reg   <= end_calc;
            frac_reg  <= in_frac;
            wh_reg    <= (in_wh == '0) ? wtcs_pkg::WALL_H_W'(1) : in_wh;
            rem_reg   <= '0;
            quo_reg   <= {cfg.nominal_tex_height, FRACTION_BITS'(0)};
        end
        if (state_reg == F_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            tx_reg  <= tx_sat;
            d_reg   <= d_calc;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                mcand_reg  <= ACC_W'(quo_next);
                mplier_reg <= d_abs[MAG_W-1:0];
                acc_reg    <= '0;
            end
        end
        if (state_reg == F_MUL)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_reg <= mplier_reg >> 1;
            tx_off_reg <= wtcs_pkg::TX_OFF_W'(tx_reg) * wtcs_pkg::TX_OFF_W'(cfg.bytes_per_texel);
        end
    end

    assign acc_ext = {1'b0, acc_reg};

    assign push          = (state_reg == F_PUSH);
    assign seg.column    = col_reg;
    assign seg.side      = side_reg;
    assign seg.first_row = first_reg;
    assign seg.end_row   = end_reg;
    assign seg.tex_x     = tx_reg;
    assign seg.tx_off    = tx_off_reg;
    assign step          = STEP_W'(quo_reg);
    assign pos           = d_reg[D_W-1] ? $signed(-acc_ext) : $signed(acc_ext);

endmodule

FILE: rtl/core/wtcs_queue.sv
// ----------------------------------------------------------------------------
// wtcs_queue
// Two-entry queue of prepared segments between the front and back parts.
// ----------------------------------------------------------------------------
module wtcs_queue
#(
    parameter int W = 134
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         pop_valid
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/wtcs_back.sv
// ----------------------------------------------------------------------------
// wtcs_back
// Walks a prepared segment one row per cycle while the result stream takes
// its output: bounds check, texel byte offset and an output register
// toward the result stream.
module wtcs_back
#(
    parameter int FRACTION_BITS = 16,
    parameter int STEP_W        = 27,
    parameter int POS_W         = 45
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  wtcs_pkg::cfg_t                    cfg,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  wtcs_pkg::seg_t                    q_seg,
    input  logic [STEP_W-1:0]                 q_step,
    input  logic signed [POS_W-1:0]           q_pos,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wtcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [wtcs_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int TY_W  = POS_W - FRACTION_BITS;
    localparam int MUL_W = wtcs_pkg::TY_OUT_W + wtcs_pkg::PITCH_W;

    logic                    gen_active_reg;
    wtcs_pkg::seg_t          seg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [wtcs_pkg::ROW_W-1:0] row_reg;

    logic                          a_valid_reg;
    logic [wtcs_pkg::COL_W-1:0]    a_col_reg;
    logic [wtcs_pkg::ROW_W-1:0]    a_row_reg;
    logic [wtcs_pkg::SIDE_W-1:0]   a_side_reg;
    logic [wtcs_pkg::TX_OFF_W-1:0] a_tx_off_reg;
    logic [wtcs_pkg::TY_OUT_W-1:0] a_ty_reg;
    logic                          a_fb_reg;
    logic                          a_last_reg;

    logic                          out_valid_reg;
    logic [wtcs_pkg::COL_W-1:0]    out_col_reg;
    logic [wtcs_pkg::ROW_W-1:0]    out_row_reg;
    logic [wtcs_pkg::SIDE_W-1:0]   out_side_reg;
    logic [wtcs_pkg::OFFSET_W-1:0] out_off_reg;
    logic                          out_fb_reg;
    logic [wtcs_pkg::COLOR_W-1:0]  out_color_reg;
    logic                          out_last_reg;

    logic                          adv;
    logic                          issue;
    logic                          row_last;
    logic                          pos_neg;
    logic [POS_W-1:0]              pos_abs;
    logic [TY_W-1:0]               ty_mag;
    logic                          fb;
    logic [wtcs_pkg::TY_OUT_W-1:0] ty;
    logic [MUL_W-1:0]              offset_sum;

    assign adv      = !out_valid_reg || m_axis_tready;
    assign issue    = adv && gen_active_reg;
    assign q_pop    = !gen_active_reg && q_valid;
    assign row_last = (row_reg == seg_reg.end_row);

    // Toward-zero truncation: a small negative position still gives row zero.
    assign pos_neg = pos_reg[POS_W-1];
    assign pos_abs = pos_neg ? POS_W'(-pos_reg) : POS_W'(pos_reg);
    assign ty_mag  = pos_abs[POS_W-1:FRACTION_BITS];
    assign ty      = pos_neg ? '0 : ty_mag[wtcs_pkg::TY_OUT_W-1:0];
    assign fb      = (wtcs_pkg::NOM_W'(seg_reg.tex_x) >= cfg.tex_width)
                     || (pos_neg ? ((ty_mag != '0) || (cfg.tex_height == '0))
                                 : (ty_mag >= TY_W'(cfg.tex_height)));

    assign offset_sum = MUL_W'(a_ty_reg) * MUL_W'(cfg.row_pitch) + MUL_W'(a_tx_off_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_active_reg <= 1'b0;
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                gen_active_reg <= 1'b1;
            end
            else if (issue && row_last)
            begin
                gen_active_reg <= 1'b0;
            end
            if (adv)
            begin
                a_valid_reg   <= gen_active_reg;
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            seg_reg  <= q_seg;
            step_reg <= q_step;
            pos_reg  <= q_pos;
            row_reg  <= q_seg.first_row;
        end
        else if (issue)
        begin
            pos_reg <= pos_reg + $signed({{(POS_W-STEP_W){1'b0}}, step_reg});
            row_reg <= row_reg + wtcs_pkg::ROW_W'(1);
        end
        if (adv)
        begin
            a_col_reg    <= seg_reg.column;
            a_row_reg    <= row_reg;
            a_side_reg   <= seg_reg.side;
            a_tx_off_reg <= seg_reg.tx_off;
            a_ty_reg     <= ty;
            a_fb_reg     <= fb;
            a_last_reg   <= row_last;

            out_col_reg   <= a_col_reg;
            out_row_reg   <= a_row_reg;
            out_side_reg  <= a_side_reg;
            out_off_reg   <= a_fb_reg ? '0 : offset_sum[wtcs_pkg::OFFSET_W-1:0];
            out_fb_reg    <= a_fb_reg;
            out_color_reg <= a_fb_reg ? cfg.fallback_color : '0;
            out_last_reg  <= a_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_off_reg, out_row_reg, out_col_reg};
    assign m_axis_tuser  = {out_fb_reg, out_side_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/core/wall_texture_column_sampler.sv
// ----------------------------------------------------------------------------
// wall_texture_column_sampler
// A request passes the front part, a two-entry queue and the back part, which
// gives one row per cycle while the output is taken. The front part takes a
// new request only when idle, runs its bit-serial step divider and then its
// start-position multiplier, and pushes the segment; an empty run is dropped.
// The back part pops the next segment after the last row of the current one.
// Reset clears all control state and loads the register defaults.
// ----------------------------------------------------------------------------
module wall_texture_column_sampler
#(
    parameter int MAX_ROWS      = 64,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wtcs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wtcs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wtcs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // column, first_row, last_row, wall_height, hit_fraction, zero pad
    input  logic [wtcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // wall_side
    input  logic [wtcs_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_column, out_row, texel_offset, color_if_fallback
    output logic [wtcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // out_side, use_fallback
    output logic [wtcs_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int STEP_W = wtcs_pkg::NOM_W + FRACTION_BITS;
    localparam int POS_W  = STEP_W + 18;
    localparam int SEG_W  = $bits(wtcs_pkg::seg_t);
    localparam int Q_W    = SEG_W + STEP_W + POS_W;

    wtcs_pkg::cfg_t          cfg;
    logic                    push;
    logic                    push_ready;
    wtcs_pkg::seg_t          f_seg;
    logic [STEP_W-1:0]       f_step;
    logic signed [POS_W-1:0] f_pos;
    logic                    q_pop;
    logic                    q_valid;
    logic [Q_W-1:0]          q_data;
    wtcs_pkg::seg_t          b_seg;
    logic [STEP_W-1:0]       b_step;
    logic signed [POS_W-1:0] b_pos;

    wtcs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wtcs_front
    #(
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS),
        .STEP_W        (STEP_W),
        .POS_W         (POS_W)
    )
    u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_ready    (push_ready),
        .seg           (f_seg),
        .step          (f_step),
        .pos           (f_pos)
    );

    wtcs_queue
    #(
        .W (Q_W)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({f_pos, f_step, f_seg}),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_data   (q_data),
        .pop_valid  (q_valid)
    );

    assign b_seg  = q_data[SEG_W-1:0];
    assign b_step = q_data[SEG_W+STEP_W-1:SEG_W];
    assign b_pos  = $signed(q_data[Q_W-1:SEG_W+STEP_W]);

    wtcs_back
    #(
        .FRACTION_BITS (FRACTION_BITS),
        .STEP_W        (STEP_W),
        .POS_W         (POS_W)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_seg         (b_seg),
        .q_step        (b_step),
        .q_pos         (b_pos),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
